### hdl/dms_pkg.sv
// shared types, constants and codes for the decimal machine step block
package dms_pkg;

	localparam int MEM_DEPTH_DEF = 1024;
	localparam int NUM_REGS_DEF  = 4;
	localparam int WORD_BITS_DEF = 32;

	localparam int IN_ADDR_BITS = 10;
	localparam int DATA_BITS    = 32;

	localparam logic [1:0] FUNC_WRITE = 2'd0;
	localparam logic [1:0] FUNC_READ  = 2'd1;
	localparam logic [1:0] FUNC_EXEC  = 2'd2;

	localparam int OP_ADD   = 1;
	localparam int OP_SUB   = 2;
	localparam int OP_MUL   = 3;
	localparam int OP_LOAD  = 4;
	localparam int OP_STORE = 5;
	localparam int OP_DIV   = 8;
	localparam int OP_READN = 9;
	localparam int OP_PRINT = 10;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DECODE,
		ST_OPER,
		ST_OPWAIT,
		ST_EXEC,
		ST_ITER,
		ST_FINISH,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic take_req;
		logic mem_rd_req;
		logic mem_rd_oper;
		logic dec_start;
		logic exec_start;
		logic iter_step;
		logic finish;
		logic result_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_write;
		logic is_read;
		logic is_exec;
		logic dec_busy;
		logic need_oper;
		logic need_iter;
		logic iter_done;
	} stat_t;

endpackage

### hdl/dms_if.sv
// valid/ready channel interface carrying the request or result payload
interface dms_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/dms_ctrl.sv
// controller state machine sequencing one request at a time
module dms_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  dms_pkg::stat_t stat,
	output dms_pkg::cmd_t  cmd
);
	dms_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dms_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			dms_pkg::ST_IDLE: begin
				if (in_valid) state_nx = dms_pkg::ST_FETCH;
			end
			dms_pkg::ST_FETCH: begin
				if (stat.is_exec) state_nx = dms_pkg::ST_DECODE;
				else state_nx = dms_pkg::ST_FINISH;
			end
			dms_pkg::ST_DECODE: begin
				if (!stat.dec_busy) state_nx = dms_pkg::ST_OPER;
			end
			dms_pkg::ST_OPER: begin
				if (stat.need_oper) state_nx = dms_pkg::ST_OPWAIT;
				else state_nx = dms_pkg::ST_FINISH;
			end
			dms_pkg::ST_OPWAIT: state_nx = dms_pkg::ST_EXEC;
			dms_pkg::ST_EXEC: begin
				if (stat.need_iter) state_nx = dms_pkg::ST_ITER;
				else state_nx = dms_pkg::ST_FINISH;
			end
			dms_pkg::ST_ITER: begin
				if (stat.iter_done) state_nx = dms_pkg::ST_FINISH;
			end
			dms_pkg::ST_FINISH: state_nx = dms_pkg::ST_OUT;
			dms_pkg::ST_OUT: begin
				if (out_ready) state_nx = dms_pkg::ST_IDLE;
			end
			default: state_nx = dms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			dms_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.take_req = in_valid;
			end
			dms_pkg::ST_FETCH: begin
				cmd.mem_rd_req = stat.is_exec || stat.is_read;
				cmd.dec_start  = stat.is_exec;
			end
			dms_pkg::ST_DECODE: ;
			dms_pkg::ST_OPER: cmd.mem_rd_oper = stat.need_oper;
			dms_pkg::ST_OPWAIT: ;
			dms_pkg::ST_EXEC: cmd.exec_start = 1'b1;
			dms_pkg::ST_ITER: cmd.iter_step = 1'b1;
			dms_pkg::ST_FINISH: cmd.finish = 1'b1;
			dms_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
		cmd.result_load = 1'b0;
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dms_pkg::ST_OUT && !out_ready) |=> state_q == dms_pkg::ST_OUT)
		else $error("result dropped while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != dms_pkg::ST_IDLE) |-> !in_ready)
		else $error("request accepted while busy");
	a_iter_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dms_pkg::ST_ITER) |-> ($past(state_q) == dms_pkg::ST_ITER
			|| $past(state_q) == dms_pkg::ST_EXEC))
		else $error("iteration entered without start");
endmodule

### hdl/dms_dp.sv
// datapath: word memory, register file, decimal decode and shared mul/div unit
module dms_dp #(
	parameter int MEM_DEPTH = dms_pkg::MEM_DEPTH_DEF,
	parameter int NUM_REGS  = dms_pkg::NUM_REGS_DEF,
	parameter int WORD_BITS = dms_pkg::WORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  dms_pkg::cmd_t                    cmd,
	output dms_pkg::stat_t                   stat,
	input  logic [1:0]                       func,
	input  logic [dms_pkg::IN_ADDR_BITS-1:0] word_address,
	input  logic signed [dms_pkg::DATA_BITS-1:0] data_value,
	output logic signed [dms_pkg::DATA_BITS-1:0] out_value,
	output logic                             out_flag,
	output logic                             fault
);
	localparam int AW = $clog2(MEM_DEPTH);
	localparam int RW = $clog2(NUM_REGS);
	localparam int CW = $clog2(WORD_BITS + 1);
	localparam int DW = (WORD_BITS > 32) ? WORD_BITS : 32;
	// opcode split works on 16-bit chunks of the word, most significant first
	localparam int NCH = (WORD_BITS + 15) / 16;
	localparam int PW  = NCH * 16;
	localparam int NCW = $clog2(NCH + 1);
	// ceil(2^44 / 10000), exact quotient for any dividend below 2^30
	localparam logic [30:0] DEC_RECIP = 31'd1759218605;

	logic [WORD_BITS-1:0] mem [MEM_DEPTH];
	logic [WORD_BITS-1:0] regs_q [NUM_REGS];

	logic [1:0]           func_q;
	logic [AW-1:0]        addr_q;
	logic [WORD_BITS-1:0] data_q;
	logic [WORD_BITS-1:0] rd_q;

	// decode: opcode by reciprocal multiply per chunk, then register digit by subtraction
	logic [WORD_BITS-1:0] rem_q;
	logic [DW-1:0]        opc_q;
	logic [3:0]           rdig_q;
	logic                 dec_busy_q;
	logic                 dec_phase_q;
	logic [AW-1:0]        oa_q;
	logic                 neg_q;
	logic [PW-1:0]        sh_q;
	logic [NCW-1:0]       chk_q;

	logic [WORD_BITS-1:0] acc_q, opa_q, opb_q;
	logic [CW-1:0]        cnt_q;
	logic                 is_div_q, qneg_q;
	logic [WORD_BITS-1:0] oper_q;
	logic signed [dms_pkg::DATA_BITS-1:0] val_q;
	logic                 vld_q, flt_q;
	logic                 is_div_next;
	logic                 dec_load_q;

	// address reduction modulo depth (index below five times depth assumed for in range)
	function automatic logic [AW-1:0] mod_addr(input logic [11:0] a);
		logic [12:0] t;
		t = {1'b0, a};
		if (t >= 13'(MEM_DEPTH)) t = t - 13'(MEM_DEPTH);
		if (t >= 13'(MEM_DEPTH)) t = t - 13'(MEM_DEPTH);
		if (t >= 13'(MEM_DEPTH)) t = t - 13'(MEM_DEPTH);
		if (t >= 13'(MEM_DEPTH)) t = t - 13'(MEM_DEPTH);
		return AW'(t);
	endfunction

	function automatic logic [dms_pkg::DATA_BITS-1:0] to_out(input logic [WORD_BITS-1:0] w);
		logic [DW-1:0] s;
		s = DW'($signed(w));
		return s[dms_pkg::DATA_BITS-1:0];
	endfunction

	logic uses_reg, bad_reg;
	logic [RW-1:0] ridx;
	always_comb begin
		uses_reg = opc_q == DW'(dms_pkg::OP_ADD) || opc_q == DW'(dms_pkg::OP_SUB)
			|| opc_q == DW'(dms_pkg::OP_MUL) || opc_q == DW'(dms_pkg::OP_LOAD)
			|| opc_q == DW'(dms_pkg::OP_STORE) || opc_q == DW'(dms_pkg::OP_DIV);
		bad_reg  = {28'd0, rdig_q} >= NUM_REGS;
		ridx     = RW'(rdig_q);
	end

	logic [WORD_BITS-1:0] rval;
	assign rval = regs_q[ridx];

	assign is_div_next = opc_q == DW'(dms_pkg::OP_DIV);

	// one chunk of the long division by 10000
	logic [29:0] dx;
	logic [60:0] dprod;
	logic [15:0] dq;
	logic [13:0] dr;
	assign dx    = {rem_q[13:0], sh_q[PW-1 -: 16]};
	assign dprod = 61'(dx) * 61'(DEC_RECIP);
	assign dq    = dprod[59:44];
	assign dr    = 14'(dx - 30'(dq) * 30'd10000);

	assign stat.is_write  = func_q == dms_pkg::FUNC_WRITE;
	assign stat.is_read   = func_q == dms_pkg::FUNC_READ;
	assign stat.is_exec   = func_q == dms_pkg::FUNC_EXEC;
	assign stat.dec_busy  = dec_busy_q || dec_load_q;
	assign stat.need_oper = !neg_q && ((uses_reg && !bad_reg)
		|| opc_q == DW'(dms_pkg::OP_READN) || opc_q == DW'(dms_pkg::OP_PRINT));
	assign stat.need_iter = !neg_q && uses_reg && !bad_reg
		&& ((opc_q == DW'(dms_pkg::OP_MUL))
		|| (opc_q == DW'(dms_pkg::OP_DIV) && rd_q != '0));
	assign stat.iter_done = cnt_q == CW'(1);

	// memory port: single write, single registered read
	logic [AW-1:0] rd_addr;
	assign rd_addr = cmd.mem_rd_oper ? oa_q : addr_q;
	always_ff @(posedge clk) begin
		if (cmd.mem_rd_req || cmd.mem_rd_oper) rd_q <= mem[rd_addr];
		if (cmd.finish && func_q == dms_pkg::FUNC_WRITE) mem[addr_q] <= data_q;
		if (cmd.exec_start && !neg_q) begin
			if (opc_q == DW'(dms_pkg::OP_STORE) && !bad_reg) mem[oa_q] <= rval;
			else if (opc_q == DW'(dms_pkg::OP_READN)) mem[oa_q] <= data_q;
		end
	end

	logic [WORD_BITS-1:0] absa, absb;
	assign absa = rval[WORD_BITS-1] ? -rval : rval;
	assign absb = rd_q[WORD_BITS-1] ? -rd_q : rd_q;

	logic [WORD_BITS:0] trial;
	assign trial = {acc_q, opa_q[WORD_BITS-1]} - {1'b0, opb_q};

	always_ff @(posedge clk) begin
		if (cmd.take_req) begin
			func_q <= func;
			addr_q <= mod_addr(12'(word_address));
			data_q <= WORD_BITS'(DW'(data_value));
		end
		if (cmd.dec_start) begin
			dec_phase_q <= 1'b0;
			opc_q       <= '0;
			rdig_q      <= '0;
		end else if (dec_load_q) begin
			rem_q <= '0;
			sh_q  <= PW'(rd_q);
			chk_q <= NCW'(NCH);
			neg_q <= rd_q[WORD_BITS-1];
		end else if (dec_busy_q) begin
			if (!dec_phase_q) begin
				rem_q <= WORD_BITS'(dr);
				sh_q  <= {sh_q[PW-17:0], 16'd0};
				opc_q <= {opc_q[DW-17:0], dq};
				chk_q <= chk_q - NCW'(1);
				if (chk_q == NCW'(1)) dec_phase_q <= 1'b1;
			end else if (rem_q >= WORD_BITS'(1000)) begin
				rem_q  <= rem_q - WORD_BITS'(1000);
				rdig_q <= rdig_q + 4'd1;
			end else begin
				oa_q <= mod_addr(12'(rem_q[9:0]));
			end
		end
		if (cmd.mem_rd_oper) ;
		if (cmd.exec_start) begin
			oper_q <= rd_q;
			opb_q  <= is_div_next ? absb : rd_q;
			opa_q  <= is_div_next ? absa : rd_q;
			acc_q  <= '0;
			cnt_q  <= CW'(WORD_BITS);
			is_div_q <= is_div_next;
			qneg_q <= rval[WORD_BITS-1] ^ rd_q[WORD_BITS-1];
		end else if (cmd.iter_step) begin
			cnt_q <= cnt_q - CW'(1);
			if (is_div_q) begin
				if (!trial[WORD_BITS]) begin
					acc_q <= trial[WORD_BITS-1:0];
					opa_q <= {opa_q[WORD_BITS-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[WORD_BITS-2:0], opa_q[WORD_BITS-1]};
					opa_q <= {opa_q[WORD_BITS-2:0], 1'b0};
				end
			end else begin
				// shift-add: acc = acc*2 + (b msb ? reg : 0)
				acc_q <= {acc_q[WORD_BITS-2:0], 1'b0} + (opb_q[WORD_BITS-1] ? rval : '0);
				opb_q <= {opb_q[WORD_BITS-2:0], 1'b0};
			end
		end
		if (cmd.finish) begin
			val_q <= '0;
			vld_q <= 1'b0;
			flt_q <= 1'b0;
			if (func_q == dms_pkg::FUNC_READ) begin
				val_q <= to_out(rd_q);
				vld_q <= 1'b1;
			end else if (func_q == dms_pkg::FUNC_EXEC && !neg_q) begin
				if (uses_reg && bad_reg) flt_q <= 1'b1;
				else if (uses_reg && opc_q == DW'(dms_pkg::OP_DIV) && oper_q == '0)
					flt_q <= 1'b1;
				else if (opc_q == DW'(dms_pkg::OP_PRINT)) begin
					val_q <= to_out(oper_q);
					vld_q <= 1'b1;
				end
			end
		end
	end

	// decode runs while the controller waits; chunks loaded from fetched word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_busy_q <= 1'b0;
			dec_load_q <= 1'b0;
		end else begin
			dec_load_q <= cmd.dec_start;
			if (dec_load_q) dec_busy_q <= 1'b1;
			else if (dec_busy_q && dec_phase_q && rem_q < WORD_BITS'(1000))
				dec_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
		end else if (cmd.finish && func_q == dms_pkg::FUNC_EXEC && !neg_q
				&& uses_reg && !bad_reg) begin
			case (opc_q)
				DW'(dms_pkg::OP_ADD):  regs_q[ridx] <= rval + oper_q;
				DW'(dms_pkg::OP_SUB):  regs_q[ridx] <= rval - oper_q;
				DW'(dms_pkg::OP_MUL):  regs_q[ridx] <= acc_q;
				DW'(dms_pkg::OP_LOAD): regs_q[ridx] <= oper_q;
				DW'(dms_pkg::OP_DIV): begin
					if (oper_q != '0) regs_q[ridx] <= qneg_q ? -opa_q : opa_q;
				end
				default: ;
			endcase
		end
	end

	assign out_value = val_q;
	assign out_flag  = vld_q;
	assign fault     = flt_q;

	a_dec_done: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_busy_q && dec_phase_q && rem_q < WORD_BITS'(1000)) |=> !dec_busy_q)
		else $error("decode did not finish");
	a_rdig: assert property (@(posedge clk) disable iff (!arst_n)
		(dec_busy_q && dec_phase_q && rem_q < WORD_BITS'(1000)) |-> rdig_q <= 4'd9)
		else $error("register digit out of range");
	a_print_fault: assert property (@(posedge clk) disable iff (!arst_n)
		!(vld_q === 1'b1 && flt_q === 1'b1))
		else $error("result both valid and faulted");
endmodule

### hdl/decimal_machine_step.sv
// top level of the decimal machine step block
// One request is taken at a time and its result must be taken before the next
// request is accepted. A memory write or read passes through fetch and finish
// to the result state. An executed instruction is decoded while the controller
// waits: the opcode is split off by a reciprocal multiply on one 16-bit chunk
// of the word per cycle, then the register digit by subtraction of 1000. A bad
// register digit, a negative word or an opcode without an operand skips the
// operand wait and execute states. Multiply and divide then iterate over the
// bits of the word in the shared shift unit. A stalled result adds its stall.
// Memory has no reset pass.
module decimal_machine_step #(
	parameter int MEM_DEPTH = dms_pkg::MEM_DEPTH_DEF,
	parameter int NUM_REGS  = dms_pkg::NUM_REGS_DEF,
	parameter int WORD_BITS = dms_pkg::WORD_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	dms_if.sink   req,
	dms_if.source res
);
	dms_pkg::cmd_t  cmd;
	dms_pkg::stat_t stat;
	logic           o_valid;
	logic signed [31:0] o_val;
	logic           o_flag, o_fault;

	dms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (o_valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dms_dp #(
		.MEM_DEPTH (MEM_DEPTH),
		.NUM_REGS  (NUM_REGS),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (req.data.func),
		.word_address (req.data.word_address),
		.data_value   (req.data.data_value),
		.out_value    (o_val),
		.out_flag     (o_flag),
		.fault        (o_fault)
	);

	assign res.valid          = o_valid;
	assign res.data.out_value = o_val;
	assign res.data.out_valid = o_flag;
	assign res.data.fault     = o_fault;
endmodule

### bench/testbench.sv
// self-checking bench for the decimal machine step block
module testbench;

	typedef struct packed {
		logic [1:0]         func;
		logic [9:0]         word_address;
		logic signed [31:0] data_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] out_value;
		logic               out_valid;
		logic               fault;
	} res_t;

	localparam int FUNC_NONE = 3;
	localparam int OP_SPARE  = 6;
	localparam int STALL_LIMIT = 600000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dms_if #(.payload_t(req_t)) req_ch ();
	dms_if #(.payload_t(res_t)) res_ch ();

	decimal_machine_step uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.res(res_ch)
	);

	always #2 clk = ~clk;

	// shadow machine state
	logic [31:0] mem_words [0:1023];
	bit          mem_known [0:1023];
	int          known_list[$];
	logic [31:0] regs [0:3];

	res_t expected_q[$];
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   errors = 0;
	int   stall_cycles = 0;
	int   n_items = 0, n_exec = 0, n_fault = 0, n_print = 0;

	function automatic int make_instr(int opc, int rd, int oa);
		return opc * 10000 + rd * 1000 + oa;
	endfunction

	function automatic void note_write(int a, logic [31:0] v);
		mem_words[a] = v;
		if (!mem_known[a]) begin
			mem_known[a] = 1'b1;
			known_list.push_back(a);
		end
	endfunction

	function automatic logic [31:0] signed_quot(logic [31:0] a, logic [31:0] b);
		logic [31:0] ua, ub, q;
		ua = a[31] ? -a : a;
		ub = b[31] ? -b : b;
		q = ua / ub;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	// compute the result of one request and update the shadow state
	function automatic res_t machine_step(req_t r);
		res_t o;
		logic [31:0] w, m;
		int opc, rd, oa;
		bit uses_reg;
		o = '0;
		case (r.func)
			dms_pkg::FUNC_WRITE: note_write(r.word_address, r.data_value);
			dms_pkg::FUNC_READ: begin
				o.out_value = mem_words[r.word_address];
				o.out_valid = 1'b1;
			end
			dms_pkg::FUNC_EXEC: begin
				w = mem_words[r.word_address];
				if (!w[31]) begin
					opc = w / 10000;
					rd = (w % 10000) / 1000;
					oa = w % 1000;
					uses_reg = opc inside {dms_pkg::OP_ADD, dms_pkg::OP_SUB,
						dms_pkg::OP_MUL, dms_pkg::OP_LOAD, dms_pkg::OP_STORE,
						dms_pkg::OP_DIV};
					if (uses_reg && rd >= 4) begin
						o.fault = 1'b1;
					end else if (uses_reg) begin
						m = mem_words[oa];
						case (opc)
							dms_pkg::OP_ADD:   regs[rd] = regs[rd] + m;
							dms_pkg::OP_SUB:   regs[rd] = regs[rd] - m;
							dms_pkg::OP_MUL:   regs[rd] = regs[rd] * m;
							dms_pkg::OP_LOAD:  regs[rd] = m;
							dms_pkg::OP_STORE: note_write(oa, regs[rd]);
							default: begin
								if (m == 0)
									o.fault = 1'b1;
								else
									regs[rd] = signed_quot(regs[rd], m);
							end
						endcase
					end else if (opc == dms_pkg::OP_READN) begin
						note_write(oa, r.data_value);
					end else if (opc == dms_pkg::OP_PRINT) begin
						o.out_value = mem_words[oa];
						o.out_valid = 1'b1;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// request side
	task automatic send_item(logic [1:0] f, int a, logic [31:0] d);
		req_t r;
		r.func = f;
		r.word_address = a;
		r.data_value = d;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.data <= r;
		do @(posedge clk); while (!req_ch.ready);
		expected_q.push_back(machine_step(r));
		n_items++;
		if (f == dms_pkg::FUNC_EXEC) n_exec++;
	endtask

	task automatic drain;
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_q.size() > 0) @(posedge clk);
	endtask

	// result side
	always @(negedge clk) begin
		if (arst_n)
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		res_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result with nothing outstanding: %p", res_ch.data);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (res_ch.data.out_value !== e.out_value) begin
					$error("out_value expected %0d got %0d", e.out_value, res_ch.data.out_value);
					errors++;
				end
				if (res_ch.data.out_valid !== e.out_valid) begin
					$error("out_valid expected %0b got %0b", e.out_valid, res_ch.data.out_valid);
					errors++;
				end
				if (res_ch.data.fault !== e.fault) begin
					$error("fault expected %0b got %0b", e.fault, res_ch.data.fault);
					errors++;
				end
				if (e.fault) n_fault++;
				if (e.out_valid) n_print++;
			end
		end
	end

	// watchdog on lack of progress
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("decimal_machine_step test failed");
			$finish;
		end
	end

	function automatic int pick_known(bit below_1000);
		int a;
		repeat (50) begin
			a = known_list[$urandom_range(known_list.size() - 1)];
			if (!below_1000 || a < 1000) return a;
		end
		return -1;
	endfunction

	function automatic int random_instr();
		int opc, rd, oa, k;
		k = $urandom_range(11);
		case (k)
			0: opc = dms_pkg::OP_ADD;
			1: opc = dms_pkg::OP_SUB;
			2: opc = dms_pkg::OP_MUL;
			3: opc = dms_pkg::OP_LOAD;
			4: opc = dms_pkg::OP_STORE;
			5: opc = dms_pkg::OP_DIV;
			6: opc = dms_pkg::OP_READN;
			7: opc = dms_pkg::OP_PRINT;
			8: opc = OP_SPARE;
			9: opc = $urandom_range(dms_pkg::OP_PRINT + 10, dms_pkg::OP_PRINT + 1);
			10: opc = dms_pkg::OP_DIV;
			default: opc = dms_pkg::OP_MUL;
		endcase
		rd = ($urandom_range(9) == 0) ? $urandom_range(9, 4) : $urandom_range(3);
		oa = pick_known(1);
		if (oa < 0) oa = 0;
		return make_instr(opc, rd, oa);
	endfunction

	// an instruction is runnable when the operand that it reads, if any, is defined
	function automatic bit runnable(int a);
		logic [31:0] w;
		int opc, rd;
		w = mem_words[a];
		if (w[31]) return 1'b1;
		opc = w / 10000;
		rd = (w % 10000) / 1000;
		if (opc inside {dms_pkg::OP_ADD, dms_pkg::OP_SUB, dms_pkg::OP_MUL,
				dms_pkg::OP_LOAD, dms_pkg::OP_DIV} && rd < 4)
			return mem_known[w % 1000];
		if (opc == dms_pkg::OP_PRINT)
			return mem_known[w % 1000];
		return 1'b1;
	endfunction

	task automatic test_directed;
		send_item(dms_pkg::FUNC_WRITE, 103, 32'h8000_0000);
		send_item(dms_pkg::FUNC_WRITE, 104, 32'hffff_ffff);
		send_item(dms_pkg::FUNC_WRITE, 102, 32'd0);
		send_item(dms_pkg::FUNC_WRITE, 101, -32'sd3);
		send_item(dms_pkg::FUNC_WRITE, 1023, make_instr(dms_pkg::OP_LOAD, 0, 103));
		send_item(dms_pkg::FUNC_EXEC, 1023, 32'd0);
		// most negative over minus one wraps
		send_item(dms_pkg::FUNC_WRITE, 0, make_instr(dms_pkg::OP_DIV, 0, 104));
		send_item(dms_pkg::FUNC_EXEC, 0, 32'hffff_ffff);
		send_item(dms_pkg::FUNC_WRITE, 1, make_instr(dms_pkg::OP_STORE, 0, 105));
		send_item(dms_pkg::FUNC_EXEC, 1, 32'd0);
		send_item(dms_pkg::FUNC_READ, 105, 32'd0);
		send_item(dms_pkg::FUNC_WRITE, 2, make_instr(dms_pkg::OP_DIV, 1, 102));
		send_item(dms_pkg::FUNC_EXEC, 2, 32'd0);
		send_item(dms_pkg::FUNC_WRITE, 3, make_instr(dms_pkg::OP_ADD, 7, 101));
		send_item(dms_pkg::FUNC_EXEC, 3, 32'd0);
		send_item(dms_pkg::FUNC_WRITE, 4, make_instr(dms_pkg::OP_READN, 9, 106));
		send_item(dms_pkg::FUNC_EXEC, 4, 32'h7fff_ffff);
		send_item(dms_pkg::FUNC_WRITE, 5, make_instr(dms_pkg::OP_PRINT, 0, 106));
		send_item(dms_pkg::FUNC_EXEC, 5, 32'd0);
		send_item(dms_pkg::FUNC_WRITE, 6, -32'sd5);
		send_item(dms_pkg::FUNC_EXEC, 6, 32'd0);
		send_item(dms_pkg::FUNC_WRITE, 7, make_instr(dms_pkg::OP_SUB, 3, 101));
		send_item(dms_pkg::FUNC_EXEC, 7, 32'd0);
		send_item(FUNC_NONE, 1023, 32'hffff_ffff);
		send_item(dms_pkg::FUNC_READ, 0, 32'd0);
	endtask

	task automatic test_random(int count);
		int k, a;
		bit done;
		repeat (count) begin
			k = $urandom_range(99);
			done = 1'b0;
			if (k >= 58) begin
				repeat (20) begin
					a = pick_known(0);
					if (!done && runnable(a)) begin
						send_item(dms_pkg::FUNC_EXEC, a, $urandom);
						done = 1'b1;
					end
				end
				if (!done) k = 0;
			end
			if (done) ;
			else if (k < 30)
				send_item(dms_pkg::FUNC_WRITE, $urandom_range(1023), random_instr());
			else if (k < 45)
				send_item(dms_pkg::FUNC_WRITE, $urandom_range(1023),
					$urandom_range(1) ? $urandom : $urandom_range(40) - 20);
			else if (k < 55)
				send_item(dms_pkg::FUNC_READ, pick_known(0), $urandom);
			else
				send_item(FUNC_NONE, $urandom_range(1023), $urandom);
		end
	endtask

	initial begin
		foreach (mem_known[i]) mem_known[i] = 1'b0;
		foreach (mem_words[i]) mem_words[i] = '0;
		foreach (regs[i]) regs[i] = '0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		drain();
		send_idle_pct = 32;
		recv_idle_pct = 73;
		test_random(250);
		drain();
		send_idle_pct = 73;
		recv_idle_pct = 32;
		test_random(250);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(250);
		drain();
		repeat (200) @(posedge clk);

		$display("covered %0d requests, %0d executed instructions", n_items, n_exec);
		$display("%0d faults and %0d words returned were checked", n_fault, n_print);
		if (errors == 0)
			$display("decimal_machine_step test passed");
		else
			$display("decimal_machine_step test failed");
		$finish;
	end

endmodule

### sim.f
hdl/dms_pkg.sv
hdl/dms_if.sv
hdl/dms_ctrl.sv
hdl/dms_dp.sv
hdl/decimal_machine_step.sv
bench/testbench.sv
